FILE: src/grsa_pkg.sv
// Shared types and constants for the glyph raster scan address generator.
`timescale 1ns / 1ps

package grsa_pkg;

    localparam int MAX_GLYPH_DIM = 8;
    localparam int MAX_SCALE     = 8;
    localparam int MAX_GLYPHS    = 256;

    localparam int DIM_W     = 4;
    localparam int ROT_W     = 2;
    localparam int COUNT_W   = 9;
    localparam int POS_W     = 7;
    localparam int COORD_W   = 3;
    localparam int INDEX_W   = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Rotation and layout codes as they are held in the registers.
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;
    localparam logic LAYOUT_STACKED = 1'b0;
    localparam logic LAYOUT_SIDE    = 1'b1;

    typedef enum logic [1:0] {
        EV_CELL    = 2'd0,
        EV_NEWLINE = 2'd1,
        EV_END     = 2'd2
    } t_event_kind;

    typedef enum logic [2:0] {
        REG_GLYPH_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_SCALE_X      = 3'd2,
        REG_SCALE_Y      = 3'd3,
        REG_ROTATION     = 3'd4,
        REG_GLYPH_COUNT  = 3'd5,
        REG_LAYOUT_MODE  = 3'd6
    } t_reg_addr;

endpackage

FILE: src/grsa_req_if.sv
// Request channel: one advance request with its restart flag.
`timescale 1ns / 1ps

interface grsa_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

FILE: src/grsa_evt_if.sv
// Event channel: one raster event per request.
`timescale 1ns / 1ps

interface grsa_evt_if import grsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_event_kind          event_kind;
    logic [INDEX_W-1:0]   glyph_index;
    logic [COORD_W-1:0]   src_col;
    logic [COORD_W-1:0]   src_row;

    modport source (output valid, output event_kind, output glyph_index,
                    output src_col, output src_row, input ready);
    modport sink (input valid, input event_kind, input glyph_index,
                  input src_col, input src_row, output ready);
endinterface

FILE: src/glyph_raster_scan_address_gen.sv
// Top level: raster scan address generator for a row of scaled, rotated glyphs.
//
//   Channel   Direction  Carries                                         Handshake
//   i_req     in         restart                                         valid/ready
//   o_evt     out        event_kind, glyph_index, src_col, src_row       valid/ready
//   APB       in/out     glyph size, scale, rotation, count, layout      psel/penable
//
// One request is accepted per clock while the sink keeps up; the edge that accepts
// it loads its event into the output register. The scan position lives in a handful
// of small counters that are read and updated in the same cycle a request is accepted,
// so they never hold off a request: one event per clock while the sink keeps up.
// A request is accepted whenever the output register is empty or being taken,
// so a stalled sink only holds off new requests while its event is waiting.
// Synchronous reset loads the register defaults and puts the scan at its start.
`timescale 1ns / 1ps

module glyph_raster_scan_address_gen import grsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    grsa_req_if.sink              i_req,
    grsa_evt_if.source            o_evt,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Clamp a register into 1..hi, as the scan logic only ever sees legal sizes.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    // One step of a scale sub-counter. Returns {sub_count, logical}.
    function automatic logic [2*COORD_W-1:0] step_sub(input logic [COORD_W-1:0] sub,
                                                      input logic [COORD_W-1:0] lg,
                                                      input logic [DIM_W-1:0] scale);
        logic [2*COORD_W-1:0] res;
        if ((DIM_W'(sub) + DIM_W'(1)) >= scale) begin
            res = {COORD_W'(0), COORD_W'(lg + COORD_W'(1))};
        end else begin
            res = {COORD_W'(sub + COORD_W'(1)), lg};
        end
        return res;
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   r_glyph_width;
    logic [DIM_W-1:0]   r_glyph_height;
    logic [DIM_W-1:0]   r_scale_x;
    logic [DIM_W-1:0]   r_scale_y;
    logic [ROT_W-1:0]   r_rotation;
    logic [COUNT_W-1:0] r_glyph_count;
    logic               r_layout_mode;

    // Scan position.
    logic [POS_W-1:0]   r_col_pos,  n_col_pos;
    logic [POS_W-1:0]   r_row_pos,  n_row_pos;
    logic [COUNT_W-1:0] r_glyph,    n_glyph;
    logic [COORD_W-1:0] r_col_sub,  n_col_sub;
    logic [COORD_W-1:0] r_row_sub,  n_row_sub;
    logic [COORD_W-1:0] r_log_col,  n_log_col;
    logic [COORD_W-1:0] r_log_row,  n_log_row;
    logic               r_finished, n_finished;

    // Output register.
    logic               r_evt_valid;
    t_event_kind        r_evt_kind,  n_evt_kind;
    logic [INDEX_W-1:0] r_evt_glyph, n_evt_glyph;
    logic [COORD_W-1:0] r_evt_col,   n_evt_col;
    logic [COORD_W-1:0] r_evt_row,   n_evt_row;

    logic [DIM_W-1:0]   w_w, w_h, w_sx, w_sy;
    logic [COUNT_W-1:0] w_cnt;
    logic [POS_W-1:0]   w_out_w, w_out_h;
    logic               w_req_fire;
    logic               w_cfg_write;
    t_reg_addr          w_reg_addr;

    assign w_reg_addr  = t_reg_addr'(paddr[APB_ADDR_W-1:2]);
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_addr)
            REG_GLYPH_WIDTH:  prdata = APB_DATA_W'(r_glyph_width);
            REG_GLYPH_HEIGHT: prdata = APB_DATA_W'(r_glyph_height);
            REG_SCALE_X:      prdata = APB_DATA_W'(r_scale_x);
            REG_SCALE_Y:      prdata = APB_DATA_W'(r_scale_y);
            REG_ROTATION:     prdata = APB_DATA_W'(r_rotation);
            REG_GLYPH_COUNT:  prdata = APB_DATA_W'(r_glyph_count);
            REG_LAYOUT_MODE:  prdata = APB_DATA_W'(r_layout_mode);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= DIM_W'(8);
            r_glyph_height <= DIM_W'(8);
            r_scale_x      <= DIM_W'(1);
            r_scale_y      <= DIM_W'(1);
            r_rotation     <= ROT_90;
            r_glyph_count  <= COUNT_W'(1);
            r_layout_mode  <= LAYOUT_STACKED;
        end else if (w_cfg_write) begin
            unique case (w_reg_addr)
                REG_GLYPH_WIDTH:  r_glyph_width  <= pwdata[DIM_W-1:0];
                REG_GLYPH_HEIGHT: r_glyph_height <= pwdata[DIM_W-1:0];
                REG_SCALE_X:      r_scale_x      <= pwdata[DIM_W-1:0];
                REG_SCALE_Y:      r_scale_y      <= pwdata[DIM_W-1:0];
                REG_ROTATION:     r_rotation     <= pwdata[ROT_W-1:0];
                REG_GLYPH_COUNT:  r_glyph_count  <= pwdata[COUNT_W-1:0];
                REG_LAYOUT_MODE:  r_layout_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Effective sizes. Odd rotations swap the glyph's width and height on the
    // output raster; each product is at most 8 x 8, so it fits in seven bits.
    assign w_w  = clamp_dim(r_glyph_width,  DIM_W'(MAX_GLYPH_DIM));
    assign w_h  = clamp_dim(r_glyph_height, DIM_W'(MAX_GLYPH_DIM));
    assign w_sx = clamp_dim(r_scale_x,      DIM_W'(MAX_SCALE));
    assign w_sy = clamp_dim(r_scale_y,      DIM_W'(MAX_SCALE));

    always_comb begin
        if (r_glyph_count == '0) begin
            w_cnt = COUNT_W'(1);
        end else if (r_glyph_count > COUNT_W'(MAX_GLYPHS)) begin
            w_cnt = COUNT_W'(MAX_GLYPHS);
        end else begin
            w_cnt = r_glyph_count;
        end
    end

    assign w_out_w = POS_W'((r_rotation[0] ? w_h : w_w) * w_sx);
    assign w_out_h = POS_W'((r_rotation[0] ? w_w : w_h) * w_sy);

    assign w_req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = !r_evt_valid || o_evt.ready;

    // Next scan state and event for the request at the input. The steps run in
    // the order of the scan: restart, then end of line / end of glyph checks,
    // then the cell lookup and column advance.
    always_comb begin
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_glyph    = r_glyph;
        n_col_sub  = r_col_sub;
        n_row_sub  = r_row_sub;
        n_log_col  = r_log_col;
        n_log_row  = r_log_row;
        n_finished = r_finished;
        n_evt_kind  = EV_CELL;
        n_evt_glyph = '0;
        n_evt_col   = '0;
        n_evt_row   = '0;

        if (i_req.restart) begin
            n_col_pos  = '0;
            n_row_pos  = '0;
            n_glyph    = '0;
            n_col_sub  = '0;
            n_row_sub  = '0;
            n_log_col  = '0;
            n_log_row  = '0;
            n_finished = 1'b0;
        end

        if (n_finished) begin
            n_evt_kind = EV_END;
        end else if (r_layout_mode == LAYOUT_STACKED) begin
            // Stacked glyphs: each output row ends in a newline, and the glyph
            // advances once its last output row is done.
            if (n_col_pos >= w_out_w) begin
                n_col_pos = '0;
                n_col_sub = '0;
                n_log_col = '0;
                n_row_pos = n_row_pos + POS_W'(1);
                {n_row_sub, n_log_row} = step_sub(n_row_sub, n_log_row, w_sy);
                n_evt_kind = EV_NEWLINE;
                if (n_row_pos >= w_out_h) begin
                    n_row_pos = '0;
                    n_row_sub = '0;
                    n_log_row = '0;
                    n_glyph   = n_glyph + COUNT_W'(1);
                end
                if (n_glyph >= w_cnt) begin
                    n_evt_kind = EV_END;
                    n_finished = 1'b1;
                end
            end
        end else begin
            // Side-by-side glyphs: an output row runs across every glyph, and
            // the newline comes after the last glyph of the row.
            if (n_col_pos >= w_out_w) begin
                n_col_pos = '0;
                n_col_sub = '0;
                n_log_col = '0;
                n_glyph   = n_glyph + COUNT_W'(1);
            end
            if (n_glyph >= w_cnt) begin
                n_glyph   = '0;
                n_row_pos = n_row_pos + POS_W'(1);
                {n_row_sub, n_log_row} = step_sub(n_row_sub, n_log_row, w_sy);
                n_evt_kind = EV_NEWLINE;
                if (n_row_pos >= w_out_h) begin
                    n_evt_kind = EV_END;
                    n_finished = 1'b1;
                end
            end
        end

        if (n_evt_kind == EV_CELL) begin
            // Rotate the logical pixel back into glyph coordinates. The
            // subtractions wrap at three bits, matching the coordinate width.
            unique case (r_rotation)
                ROT_0: begin
                    n_evt_col = n_log_col;
                    n_evt_row = n_log_row;
                end
                ROT_90: begin
                    n_evt_col = n_log_row;
                    n_evt_row = COORD_W'(w_h) - COORD_W'(1) - n_log_col;
                end
                ROT_180: begin
                    n_evt_col = COORD_W'(w_w) - COORD_W'(1) - n_log_col;
                    n_evt_row = COORD_W'(w_h) - COORD_W'(1) - n_log_row;
                end
                default: begin
                    n_evt_col = COORD_W'(w_w) - COORD_W'(1) - n_log_row;
                    n_evt_row = n_log_col;
                end
            endcase
            n_evt_glyph = n_glyph[INDEX_W-1:0];
            n_col_pos   = n_col_pos + POS_W'(1);
            {n_col_sub, n_log_col} = step_sub(n_col_sub, n_log_col, w_sx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_glyph     <= '0;
            r_col_sub   <= '0;
            r_row_sub   <= '0;
            r_log_col   <= '0;
            r_log_row   <= '0;
            r_finished  <= 1'b0;
            r_evt_valid <= 1'b0;
        end else begin
            if (w_req_fire) begin
                r_col_pos   <= n_col_pos;
                r_row_pos   <= n_row_pos;
                r_glyph     <= n_glyph;
                r_col_sub   <= n_col_sub;
                r_row_sub   <= n_row_sub;
                r_log_col   <= n_log_col;
                r_log_row   <= n_log_row;
                r_finished  <= n_finished;
                r_evt_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    // Event payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_evt_kind  <= n_evt_kind;
            r_evt_glyph <= n_evt_glyph;
            r_evt_col   <= n_evt_col;
            r_evt_row   <= n_evt_row;
        end
    end

    assign o_evt.valid       = r_evt_valid;
    assign o_evt.event_kind  = r_evt_kind;
    assign o_evt.glyph_index = r_evt_glyph;
    assign o_evt.src_col     = r_evt_col;
    assign o_evt.src_row     = r_evt_row;

    // Once the scan has finished, a request without restart must answer end.
    a_end_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_fire && r_finished && !i_req.restart)
            |=> (r_evt_valid && r_evt_kind == EV_END))
        else $error("request after end of scan did not report end");

    // Every accepted request leaves an event in the output register.
    a_req_gives_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> r_evt_valid)
        else $error("accepted request produced no event");

    // Newline and end events carry zero glyph and coordinate fields.
    a_noncell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evt_valid && r_evt_kind != EV_CELL)
            |-> (r_evt_glyph == '0 && r_evt_col == '0 && r_evt_row == '0))
        else $error("non-cell event carries nonzero fields");

endmodule

FILE: tb/glyph_raster_scan_address_gen_test.sv
// Self-checking testbench for the glyph raster scan address generator.
`timescale 1ns / 1ps

module glyph_raster_scan_address_gen_test import grsa_pkg::*; ();

    localparam int         REG_COUNT      = int'(REG_LAYOUT_MODE) + 1;

    // Register setting profiles for the random phases; any other draw is a small scan.
    localparam int PROF_MAX  = 0;
    localparam int PROF_MIN  = 1;
    localparam int PROF_WILD = 2;

    localparam int TOTAL_REQUESTS = 1950;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_event_kind        kind;
        logic [INDEX_W-1:0] glyph;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
    } t_scan_event;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_op;

    // One line of the directed plan: either a register write or a request. A request
    // row either carries its event typed in, or leaves it to the scan predictor.
    typedef struct packed {
        t_row_op     op;
        t_reg_addr   reg_sel;
        logic [31:0] value;
        logic        restart;
        logic        typed;
        t_scan_event result;
    } t_plan_row;

    localparam t_scan_event NO_EVENT = '{EV_CELL, 8'd0, 3'd0, 3'd0};

    localparam int PLAN_LEN = 37;
    localparam t_plan_row PLAN [0:PLAN_LEN-1] = '{
        // Straight out of reset the glyph is 8x8 turned by 90 degrees: the first
        // cells walk up the source column from the bottom row.
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b1, '{EV_CELL, 8'd0, 3'd0, 3'd7}},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b1, '{EV_CELL, 8'd0, 3'd0, 3'd6}},
        // A 2x2 unrotated glyph, stacked, scanned from a restart through to its end.
        '{ROW_CFG, REG_GLYPH_WIDTH, 32'd2, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 32'd2, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_ROTATION, 32'(ROT_0), 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b1, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        // Once the scan is over, every request answers end.
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b1, '{EV_END, 8'd0, 3'd0, 3'd0}},
        // Side by side, three glyphs, doubled width, turned by 180 degrees.
        '{ROW_CFG, REG_LAYOUT_MODE, 32'(LAYOUT_SIDE), 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_GLYPH_COUNT, 32'd3, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_SCALE_X, 32'd2, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_ROTATION, 32'(ROT_180), 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b1, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        // Out of range sizes, scales and counts saturate into their legal ranges.
        '{ROW_CFG, REG_ROTATION, 32'(ROT_270), 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_GLYPH_HEIGHT, 32'd15, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_SCALE_Y, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_SCALE_X, 32'd15, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_GLYPH_COUNT, 32'd511, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b1, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        // Settings changed in the middle of a scan, without a restart.
        '{ROW_CFG, REG_GLYPH_COUNT, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_CFG, REG_ROTATION, 32'(ROT_90), 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b0, 1'b0, NO_EVENT},
        '{ROW_REQ, REG_GLYPH_WIDTH, 32'd0, 1'b1, 1'b0, NO_EVENT}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    grsa_req_if req_ch ();
    grsa_evt_if evt_ch ();

    glyph_raster_scan_address_gen i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_evt   (evt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register copy, at the widths the block keeps, with the reset values.
    logic [3:0] cfg_glyph_w  = 4'd8;
    logic [3:0] cfg_glyph_h  = 4'd8;
    logic [3:0] cfg_scale_x  = 4'd1;
    logic [3:0] cfg_scale_y  = 4'd1;
    logic [1:0] cfg_rotation = ROT_90;
    logic [8:0] cfg_count    = 9'd1;
    logic       cfg_layout   = LAYOUT_STACKED;

    // Scan position as the block should hold it.
    logic [6:0] col_pos   = '0;
    logic [6:0] row_pos   = '0;
    logic [8:0] glyph_pos = '0;
    logic [2:0] col_sub   = '0;
    logic [2:0] row_sub   = '0;
    logic [2:0] lcol      = '0;
    logic [2:0] lrow      = '0;
    logic       scan_done = 1'b0;

    t_scan_event pending_events[$];

    int n_faults   = 0;
    int n_requests = 0;
    int n_restarts = 0;
    int n_checked  = 0;
    int n_cells    = 0;
    int n_newlines = 0;
    int n_ends     = 0;
    int n_settings = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #1_000_000;
        $display("glyph_raster_scan_address_gen: mismatch");
        $finish;
    end

    function automatic int clamp_range(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_col();
        col_pos = '0;
        col_sub = '0;
        lcol    = '0;
    endfunction

    function automatic void clear_row();
        row_pos = '0;
        row_sub = '0;
        lrow    = '0;
    endfunction

    // The sub-counter divides the output row by the vertical scale.
    function automatic void step_row(int sy);
        row_pos = row_pos + 7'd1;
        if (int'(row_sub) + 1 >= sy) begin
            row_sub = '0;
            lrow    = lrow + 3'd1;
        end else begin
            row_sub = row_sub + 3'd1;
        end
    endfunction

    // Works out the event for one accepted request and moves the scan position on.
    // Sizes, scales and the count are saturated at use, never when written.
    function automatic t_scan_event advance_scan(logic restart);
        int w, h, sx, sy, cnt, out_w, out_h, sc, sr;
        t_scan_event ev;
        w     = clamp_range(int'(cfg_glyph_w), MAX_GLYPH_DIM);
        h     = clamp_range(int'(cfg_glyph_h), MAX_GLYPH_DIM);
        sx    = clamp_range(int'(cfg_scale_x), MAX_SCALE);
        sy    = clamp_range(int'(cfg_scale_y), MAX_SCALE);
        cnt   = clamp_range(int'(cfg_count), MAX_GLYPHS);
        out_w = (cfg_rotation[0] ? h : w) * sx;
        out_h = (cfg_rotation[0] ? w : h) * sy;
        ev    = NO_EVENT;

        if (restart) begin
            clear_col();
            clear_row();
            glyph_pos = '0;
            scan_done = 1'b0;
        end

        if (scan_done) begin
            ev.kind = EV_END;
        end else if (cfg_layout == LAYOUT_STACKED) begin
            // Each output row of a glyph ends in a newline; the last row moves on
            // to the next glyph, and past the last glyph the scan ends.
            if (int'(col_pos) >= out_w) begin
                clear_col();
                step_row(sy);
                ev.kind = EV_NEWLINE;
                if (int'(row_pos) >= out_h) begin
                    clear_row();
                    glyph_pos = glyph_pos + 9'd1;
                end
                if (int'(glyph_pos) >= cnt) begin
                    ev.kind   = EV_END;
                    scan_done = 1'b1;
                end
            end
        end else begin
            // One output row runs across every glyph before its newline.
            if (int'(col_pos) >= out_w) begin
                clear_col();
                glyph_pos = glyph_pos + 9'd1;
            end
            if (int'(glyph_pos) >= cnt) begin
                glyph_pos = '0;
                step_row(sy);
                ev.kind = EV_NEWLINE;
                if (int'(row_pos) >= out_h) begin
                    ev.kind   = EV_END;
                    scan_done = 1'b1;
                end
            end
        end

        if (ev.kind == EV_CELL) begin
            case (cfg_rotation)
                ROT_0: begin
                    sc = int'(lcol);
                    sr = int'(lrow);
                end
                ROT_90: begin
                    sc = int'(lrow);
                    sr = h - 1 - int'(lcol);
                end
                ROT_180: begin
                    sc = w - 1 - int'(lcol);
                    sr = h - 1 - int'(lrow);
                end
                default: begin
                    sc = w - 1 - int'(lrow);
                    sr = int'(lcol);
                end
            endcase
            // After a size change mid-scan the source coordinate may go negative;
            // only its low three bits leave the block.
            ev.src_col = sc[2:0];
            ev.src_row = sr[2:0];
            ev.glyph   = glyph_pos[7:0];
            col_pos    = col_pos + 7'd1;
            if (int'(col_sub) + 1 >= sx) begin
                col_sub = '0;
                lcol    = lcol + 3'd1;
            end else begin
                col_sub = col_sub + 3'd1;
            end
        end
        return ev;
    endfunction

    task automatic note_fault(string msg);
        n_faults++;
        if (n_faults <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Presents one request and holds it until the block takes it. Valid stays high
    // on return, so back-to-back requests never drop it in between.
    task automatic send_request(logic restart, logic typed, t_scan_event typed_ev);
        t_scan_event ev;
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do @(posedge i_clk); while (!req_ch.ready);
        ev = advance_scan(restart);
        pending_events.push_back(typed ? typed_ev : ev);
        n_requests++;
        if (restart) begin
            n_restarts++;
        end
    endtask

    // Drops the request and waits until every outstanding event has been taken.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    // Setup phase, then access phase; the register takes the data at the edge that
    // sees the access phase with pready high. The bus is left selected so writes
    // can follow back to back; apb_release ends the burst.
    task automatic write_reg(t_reg_addr sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            REG_GLYPH_WIDTH:  cfg_glyph_w  = value[3:0];
            REG_GLYPH_HEIGHT: cfg_glyph_h  = value[3:0];
            REG_SCALE_X:      cfg_scale_x  = value[3:0];
            REG_SCALE_Y:      cfg_scale_y  = value[3:0];
            REG_ROTATION:     cfg_rotation = value[1:0];
            REG_GLYPH_COUNT:  cfg_count    = value[8:0];
            REG_LAYOUT_MODE:  cfg_layout   = value[0];
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The sink switches at random between stall patterns: always ready, coin
    // flips, a regular stall with mostly flow, or equal stretches of stall and flow.
    int rx_cycle = 0;
    int rx_mode  = 0;

    always @(posedge i_clk) begin
        if (rx_cycle % 128 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       evt_ch.ready <= 1'b1;
            1:       evt_ch.ready <= 1'($urandom_range(0, 1));
            2:       evt_ch.ready <= (rx_cycle % 4 != 3);
            default: evt_ch.ready <= (rx_cycle % 16 < 8);
        endcase
        rx_cycle++;
    end

    // Every event the block hands over is matched against the oldest expectation.
    always @(posedge i_clk) begin : event_check
        t_scan_event want;
        if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
            if (pending_events.size() == 0) begin
                note_fault($sformatf("Unrequested event: kind %0d glyph %0d col %0d row %0d",
                    evt_ch.event_kind, evt_ch.glyph_index, evt_ch.src_col, evt_ch.src_row));
            end else begin
                want = pending_events.pop_front();
                n_checked++;
                if (want.kind == EV_CELL) begin
                    n_cells++;
                end else if (want.kind == EV_NEWLINE) begin
                    n_newlines++;
                end else begin
                    n_ends++;
                end
                if (evt_ch.event_kind !== want.kind || evt_ch.glyph_index !== want.glyph
                        || evt_ch.src_col !== want.src_col
                        || evt_ch.src_row !== want.src_row) begin
                    note_fault($sformatf(
                        "Event %0d: want kind %0d glyph %0d col %0d row %0d, got %0d %0d %0d %0d",
                        n_checked, want.kind, want.glyph, want.src_col, want.src_row,
                        evt_ch.event_kind, evt_ch.glyph_index, evt_ch.src_col,
                        evt_ch.src_row));
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] values [REG_COUNT];
        logic        on_bus;
        logic        restart;
        int          profile, items, pause_at, burst, gap, phase;
        logic        no_gaps;

        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;
        on_bus         = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan. A run of register rows is written only once the block
        // has handed over everything it owes.
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].op == ROW_CFG) begin
                if (!on_bus) begin
                    wait_idle();
                    n_settings++;
                end
                write_reg(PLAN[k].reg_sel, PLAN[k].value);
                on_bus = 1'b1;
            end else begin
                if (on_bus) begin
                    apb_release();
                    on_bus = 1'b0;
                end
                send_request(PLAN[k].restart, PLAN[k].typed, PLAN[k].result);
            end
        end

        // Random phases. The first two pin every register at its largest and
        // smallest setting; later ones are mostly small glyphs so that scans run
        // through to their end many times over, with some wild values in between.
        phase = 0;
        while (n_requests < TOTAL_REQUESTS) begin
            wait_idle();
            profile = (phase < 2) ? phase : $urandom_range(0, 9);
            case (profile)
                PROF_MAX: begin
                    values[REG_GLYPH_WIDTH]  = $urandom_range(0, 1) ? 32'd15 : 32'd8;
                    values[REG_GLYPH_HEIGHT] = $urandom_range(0, 1) ? 32'd15 : 32'd8;
                    values[REG_SCALE_X]      = $urandom_range(0, 1) ? 32'd15 : 32'd8;
                    values[REG_SCALE_Y]      = $urandom_range(0, 1) ? 32'd15 : 32'd8;
                    values[REG_GLYPH_COUNT]  = $urandom_range(0, 1) ? 32'd511 : 32'd256;
                end
                PROF_MIN: begin
                    values[REG_GLYPH_WIDTH]  = $urandom_range(0, 1);
                    values[REG_GLYPH_HEIGHT] = $urandom_range(0, 1);
                    values[REG_SCALE_X]      = $urandom_range(0, 1);
                    values[REG_SCALE_Y]      = $urandom_range(0, 1);
                    values[REG_GLYPH_COUNT]  = $urandom_range(0, 1);
                end
                PROF_WILD: begin
                    values[REG_GLYPH_WIDTH]  = $urandom_range(0, 15);
                    values[REG_GLYPH_HEIGHT] = $urandom_range(0, 15);
                    values[REG_SCALE_X]      = $urandom_range(0, 15);
                    values[REG_SCALE_Y]      = $urandom_range(0, 15);
                    values[REG_GLYPH_COUNT]  = $urandom_range(0, 511);
                end
                default: begin
                    values[REG_GLYPH_WIDTH]  = $urandom_range(1, 4);
                    values[REG_GLYPH_HEIGHT] = $urandom_range(1, 4);
                    values[REG_SCALE_X]      = $urandom_range(1, 3);
                    values[REG_SCALE_Y]      = $urandom_range(1, 3);
                    values[REG_GLYPH_COUNT]  = $urandom_range(1, 4);
                end
            endcase
            values[REG_ROTATION]    = (phase < 2) ? 32'(phase * 3) : $urandom_range(0, 3);
            values[REG_LAYOUT_MODE] = (phase < 2) ? 32'(phase) : $urandom_range(0, 1);

            // Later phases rewrite only some registers, which may leave a scan
            // half done under sizes it was not started with.
            for (int r = 0; r < REG_COUNT; r++) begin
                if (phase < 2 || $urandom_range(0, 3) != 0) begin
                    write_reg(t_reg_addr'(r), values[r]);
                end
            end
            apb_release();
            n_settings++;

            items    = (profile == PROF_MAX) ? 60 : $urandom_range(100, 200);
            no_gaps  = ($urandom_range(0, 3) == 0);
            pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? items / 2 : -1;
            burst    = 0;
            for (int i = 0; i < items; i++) begin
                // Now and then the sender holds off until the block has drained.
                if (i == pause_at) begin
                    wait_idle();
                end
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    gap   = no_gaps ? 0 : $urandom_range(0, 6);
                    if (gap > 0) begin
                        req_ch.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                // Restart mostly once a scan has ended, so that some end events
                // repeat, and rarely in the middle of a scan.
                if (i == 0) begin
                    restart = ($urandom_range(0, 2) != 0);
                end else if (scan_done) begin
                    restart = ($urandom_range(0, 3) != 0);
                end else begin
                    restart = ($urandom_range(0, 99) == 0);
                end
                send_request(restart, 1'b0, NO_EVENT);
                burst--;
            end
            phase++;
        end

        // Drain, then keep the clock running so that any stray event still shows.
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d requests (%0d with restart) over %0d register settings.",
            n_requests, n_restarts, n_settings);
        $display("Checked %0d events: %0d cells, %0d newlines, %0d ends; %0d faults.",
            n_checked, n_cells, n_newlines, n_ends, n_faults);
        if (n_faults == 0) begin
            $display("glyph_raster_scan_address_gen: match");
        end else begin
            $display("glyph_raster_scan_address_gen: mismatch");
        end
        $finish;
    end

endmodule

FILE: glyph_raster_scan_address_gen.f
src/grsa_pkg.sv
src/grsa_req_if.sv
src/grsa_evt_if.sv
src/glyph_raster_scan_address_gen.sv
tb/glyph_raster_scan_address_gen_test.sv
